// File: design/ctc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Columnar transposition package
// Shared widths, register indexes and the controller/datapath command types.
// ----------------------------------------------------------------------------
package ctc_pkg;

  localparam int CT_MAX_KEY_LEN = 16;
  localparam int CT_IDX_W       = 4;
  localparam int KEY_LEN_W      = 5;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 2'd0,
    REG_KEY_LENGTH = 2'd1,
    REG_KEY_LOW    = 2'd2,
    REG_KEY_HIGH   = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INIT,
    OP_LOAD,
    OP_SORT,
    OP_SORT_KEYS,
    OP_MATCH,
    OP_STORE
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [CT_IDX_W-1:0] addr;
    logic [CT_IDX_W-1:0] pivot;
    logic                run;
  } ctc_cmd_t;

  typedef struct packed {
    logic                cfg_write;
    logic                mode;
    logic [CT_IDX_W-1:0] last;
  } ctc_status_t;

endpackage

// File: design/ctc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Columnar transposition controller
// Sequences the exchange sort and key matching passes that build the column
// order, then lets the datapath stream rows.
// ----------------------------------------------------------------------------
module ctc_ctrl
  import ctc_pkg::*;
#(
  parameter int MAX_KEY_LEN = CT_MAX_KEY_LEN
) (
  input  logic        clk,
  input  logic        rst,
  input  ctc_status_t sts,
  output ctc_cmd_t    cmd
);

  localparam int IDX_W = $clog2(MAX_KEY_LEN);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_LOAD,
    ST_SCAN,
    ST_STORE,
    ST_RUN
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic             phase;
  logic [IDX_W-1:0] last;
  logic [IDX_W-1:0] i_inc;
  logic [IDX_W-1:0] j_inc;

  assign last  = sts.last[IDX_W-1:0];
  assign i_inc = i + IDX_W'(1);
  assign j_inc = j + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      i     <= '0;
      j     <= '0;
      phase <= 1'b0;
    end else if (sts.cfg_write) begin
      state <= ST_INIT;
    end else begin
      unique case (state)
        ST_INIT: begin
          i     <= '0;
          phase <= 1'b0;
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          j     <= i_inc;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (j == last) begin
            state <= ST_STORE;
          end else begin
            j <= j_inc;
          end
        end
        ST_STORE: begin
          if (i_inc == last) begin
            if (sts.mode && !phase) begin
              phase <= 1'b1;
              i     <= '0;
              state <= ST_LOAD;
            end else begin
              state <= ST_RUN;
            end
          end else begin
            i     <= i_inc;
            state <= ST_LOAD;
          end
        end
        ST_RUN: begin
          state <= ST_RUN;
        end
        default: begin
          state <= ST_INIT;
        end
      endcase
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.addr  = CT_IDX_W'(i);
    cmd.pivot = CT_IDX_W'(i);
    unique case (state)
      ST_INIT:  cmd.op = OP_INIT;
      ST_LOAD:  cmd.op = OP_LOAD;
      ST_SCAN: begin
        cmd.addr = CT_IDX_W'(j);
        if (sts.mode) begin
          cmd.op = phase ? OP_MATCH : OP_SORT_KEYS;
        end else begin
          cmd.op = OP_SORT;
        end
      end
      ST_STORE: cmd.op = OP_STORE;
      ST_RUN: begin
        cmd.op  = OP_NONE;
        cmd.run = 1'b1;
      end
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule

// File: design/ctc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Columnar transposition datapath
// Configuration registers, the sort store for the column order, a double row
// buffer and the registered output stage.
// ----------------------------------------------------------------------------
module ctc_dp
  import ctc_pkg::*;
#(
  parameter int MAX_KEY_LEN = CT_MAX_KEY_LEN
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ctc_cmd_t              cmd,
  output ctc_status_t           sts,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,
  output logic                  m_tlast
);

  localparam int IDX_W = $clog2(MAX_KEY_LEN);

  logic                  mode;
  logic [KEY_LEN_W-1:0]  key_length;
  logic [CFG_DATA_W-1:0] key_low;
  logic [CFG_DATA_W-1:0] key_high;
  logic [2*CFG_DATA_W-1:0] key_bytes;

  logic signed [7:0] srt [MAX_KEY_LEN];
  logic [IDX_W-1:0]  col [MAX_KEY_LEN];
  logic signed [7:0] cur_s;
  logic [IDX_W-1:0]  cur_c;

  logic [7:0]        rows [2][MAX_KEY_LEN];
  logic              wbank;
  logic              ebank;
  logic              ebusy;
  logic [IDX_W-1:0]  fill;
  logic [IDX_W-1:0]  ej;

  logic [KEY_LEN_W-1:0] klen_m1;
  logic [IDX_W-1:0]     last_idx;
  logic [IDX_W-1:0]     a;
  logic [IDX_W-1:0]     col_raddr;
  logic [IDX_W-1:0]     col_rd;
  logic signed [7:0]    srt_rd;
  logic signed [7:0]    pivot_char;
  logic                 swap;
  logic                 completing;
  logic                 accept;
  logic                 out_load;

  assign key_bytes = {key_high, key_low};
  assign klen_m1   = key_length - KEY_LEN_W'(1);

  always_comb begin
    if (key_length < KEY_LEN_W'(2)) begin
      last_idx = IDX_W'(1);
    end else if (key_length > KEY_LEN_W'(MAX_KEY_LEN)) begin
      last_idx = IDX_W'(MAX_KEY_LEN - 1);
    end else begin
      last_idx = klen_m1[IDX_W-1:0];
    end
  end

  assign sts.cfg_write = cfg_we;
  assign sts.mode      = mode;
  assign sts.last      = CT_IDX_W'(last_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b0;
      key_length <= KEY_LEN_W'(2);
      key_low    <= '0;
      key_high   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MODE:       mode       <= cfg_data[0];
        REG_KEY_LENGTH: key_length <= cfg_data[KEY_LEN_W-1:0];
        REG_KEY_LOW:    key_low    <= cfg_data;
        REG_KEY_HIGH:   key_high   <= cfg_data;
        default:        mode       <= mode;
      endcase
    end
  end

  assign a          = cmd.addr[IDX_W-1:0];
  assign col_raddr  = cmd.run ? ej : a;
  assign col_rd     = col[col_raddr];
  assign srt_rd     = srt[a];
  assign pivot_char = $signed(key_bytes[cmd.pivot*8 +: 8]);
  assign swap       = (cmd.op == OP_MATCH) ? (pivot_char == srt_rd) : (srt_rd < cur_s);

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_INIT: begin
        for (int k = 0; k < MAX_KEY_LEN; k++) begin
          srt[k] <= $signed(key_bytes[k*8 +: 8]);
          col[k] <= IDX_W'(k);
        end
      end
      OP_LOAD: begin
        cur_s <= srt_rd;
        cur_c <= col_rd;
      end
      OP_SORT, OP_MATCH: begin
        if (swap) begin
          srt[a] <= cur_s;
          cur_s  <= srt_rd;
          col[a] <= cur_c;
          cur_c  <= col_rd;
        end
      end
      OP_SORT_KEYS: begin
        if (swap) begin
          srt[a] <= cur_s;
          cur_s  <= srt_rd;
        end
      end
      OP_STORE: begin
        srt[a] <= cur_s;
        col[a] <= cur_c;
      end
      default: begin
        cur_s <= cur_s;
      end
    endcase
  end

  assign completing = (fill == last_idx);
  assign s_tready   = cmd.run && !(completing && ebusy);
  assign accept     = s_tvalid && s_tready;
  assign out_load   = ebusy && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (accept) begin
      rows[wbank][fill] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= rows[ebank][col_rd];
      m_tlast <= (ej == last_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      wbank    <= 1'b0;
      ebank    <= 1'b0;
      ebusy    <= 1'b0;
      ej       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        fill <= '0;
      end else if (accept) begin
        if (completing) begin
          fill  <= '0;
          wbank <= ~wbank;
          ebank <= wbank;
          ebusy <= 1'b1;
          ej    <= '0;
        end else begin
          fill <= fill + IDX_W'(1);
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
        if (ej == last_idx) begin
          ebusy <= 1'b0;
        end else begin
          ej <= ej + IDX_W'(1);
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// File: design/columnar_transposition_cipher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Columnar transposition cipher unit
// Gathers bytes into rows of key length (held within 2 to MAX_KEY_LEN) and emits
// each full row with its columns permuted by the key order.
//
//   Channel   Direction  Signals                      Contents
//   s_*       in         s_tvalid s_tready s_tdata    one data byte per item
//   m_*       out        m_tvalid m_tready m_tdata    one permuted byte per item
//                        m_tlast                      set on the last byte of a row
//   cfg_*     in         cfg_we cfg_index cfg_data    register write, no read-back
//
// Bytes are taken and emitted one per cycle while the output is ready, but the
// byte that completes a row waits until the previous row has been read out of
// the row buffer. The first byte of a row is offered once the completing byte
// has set ebusy and the first byte has then been loaded into the output register.
// After reset and every register write the column order is rebuilt with no
// input taken. Reset is synchronous.
// ----------------------------------------------------------------------------
module columnar_transposition_cipher_unit
  import ctc_pkg::*;
#(
  parameter int MAX_KEY_LEN = CT_MAX_KEY_LEN
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] data_in
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // [7:0] data_out
  output logic                  m_tlast
);

  ctc_cmd_t    cmd;
  ctc_status_t sts;

  ctc_ctrl #(
    .MAX_KEY_LEN(MAX_KEY_LEN)
  ) u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  ctc_dp #(
    .MAX_KEY_LEN(MAX_KEY_LEN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
